### rtl/qxmm_pkg.sv
`default_nettype none

package qxmm_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ARM_OFFSET     = 3'd0;
  localparam logic [2:0] REG_TORQUE_COEFF   = 3'd1;
  localparam logic [2:0] REG_ROLL_PITCH_GN  = 3'd2;
  localparam logic [2:0] REG_YAW_GAIN       = 3'd3;
  localparam logic [2:0] REG_THRUST_FLOOR   = 3'd4;
  localparam logic [2:0] REG_THRUST_CEILING = 3'd5;

  // register reset values
  localparam logic [30:0]        ARM_OFFSET_RST     = 31'd65536;
  localparam logic [30:0]        TORQUE_COEFF_RST   = 31'd65536;
  localparam logic [30:0]        ROLL_PITCH_GN_RST  = 31'd16384;
  localparam logic [30:0]        YAW_GAIN_RST       = 31'd16384;
  localparam logic signed [31:0] THRUST_FLOOR_RST   = 32'sd0;
  localparam logic signed [31:0] THRUST_CEILING_RST = 32'sd655360;

  // per-motor sign of the inverse mixing columns, bit set = negative
  localparam logic [3:0] ROLL_NEG  = 4'b0011;
  localparam logic [3:0] PITCH_NEG = 4'b0110;
  localparam logic [3:0] YAW_NEG   = 4'b0101;

  // axis order of the rounded torque terms
  localparam int unsigned AXIS_ROLL  = 0;
  localparam int unsigned AXIS_PITCH = 1;
  localparam int unsigned AXIS_YAW   = 2;

  localparam int unsigned MOTORS = 4;

  // load enables of the two merge stages
  typedef struct packed {
    logic sum_en;
    logic mul_en;
  } qxmm_merge_ctl_t;

  // saturate a wide signed value to the 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/qxmm_if.sv
`default_nettype none

// command channel
interface qxmm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] thrust_command;
  logic signed [31:0] roll_torque;
  logic signed [31:0] pitch_torque;
  logic signed [31:0] yaw_torque;
  logic               torque_present;
  logic [3:0]         failed_mask;

  modport source (
    output valid, thrust_command, roll_torque, pitch_torque, yaw_torque,
    output torque_present, failed_mask,
    input  ready
  );
  modport sink (
    input  valid, thrust_command, roll_torque, pitch_torque, yaw_torque,
    input  torque_present, failed_mask,
    output ready
  );
endinterface

// result channel
interface qxmm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] motor_one_thrust;
  logic signed [31:0] motor_two_thrust;
  logic signed [31:0] motor_three_thrust;
  logic signed [31:0] motor_four_thrust;
  logic signed [31:0] achieved_thrust;
  logic signed [31:0] achieved_roll;
  logic signed [31:0] achieved_pitch;
  logic signed [31:0] achieved_yaw;

  modport source (
    output valid, motor_one_thrust, motor_two_thrust, motor_three_thrust,
    output motor_four_thrust, achieved_thrust, achieved_roll, achieved_pitch,
    output achieved_yaw,
    input  ready
  );
  modport sink (
    input  valid, motor_one_thrust, motor_two_thrust, motor_three_thrust,
    input  motor_four_thrust, achieved_thrust, achieved_roll, achieved_pitch,
    input  achieved_yaw,
    output ready
  );
endinterface

// register write channel
interface qxmm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/qxmm_lane.sv
`default_nettype none

// one motor: pick signed terms, sum, clamp, failure gate
module qxmm_lane import qxmm_pkg::*; #(
  parameter int unsigned LANE_ID = 0,
  parameter int unsigned TERM_W  = 48
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic signed [30:0]           base_i,
  input  wire logic [2:0][1:0][TERM_W-1:0]  terms_i,
  input  wire logic                         failed_i,
  input  wire logic signed [31:0]           floor_i,
  input  wire logic signed [31:0]           ceiling_i,
  output logic signed [31:0]                f_o
);

  localparam int unsigned SUM_W = TERM_W + 2;

  logic signed [TERM_W-1:0] roll_t, pitch_t, yaw_t;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  clamped;
  logic signed [31:0]       f_d;
  logic signed [31:0]       f_q;

  // term selection by this motor's column signs
  assign roll_t  = $signed(terms_i[AXIS_ROLL][ROLL_NEG[LANE_ID]]);
  assign pitch_t = $signed(terms_i[AXIS_PITCH][PITCH_NEG[LANE_ID]]);
  assign yaw_t   = $signed(terms_i[AXIS_YAW][YAW_NEG[LANE_ID]]);

  // sum, clamp with floor winning, then failure gate
  always_comb begin
    sum = SUM_W'(base_i) + SUM_W'(roll_t) + SUM_W'(pitch_t) + SUM_W'(yaw_t);
    clamped = sum;
    if (clamped > SUM_W'(ceiling_i)) begin
      clamped = SUM_W'(ceiling_i);
    end
    if (clamped < SUM_W'(floor_i)) begin
      clamped = SUM_W'(floor_i);
    end
    f_d = failed_i ? 32'sd0 : clamped[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= f_d;
    end
  end

  assign f_o = f_q;

endmodule

`default_nettype wire

### rtl/qxmm_merge.sv
`default_nettype none

// forward matrix: combine the lane thrusts into the achieved wrench
module qxmm_merge import qxmm_pkg::*; (
  input  wire logic                     clk_i,
  input  wire qxmm_merge_ctl_t          ctl_i,
  input  wire logic [3:0][31:0]         f_i,
  input  wire logic [30:0]              arm_offset_i,
  input  wire logic [30:0]              torque_coeff_i,
  output logic signed [31:0]            thrust_o,
  output logic signed [65:0]            roll_prod_o,
  output logic signed [65:0]            pitch_prod_o,
  output logic signed [65:0]            yaw_prod_o
);

  logic signed [33:0] f0, f1, f2, f3;
  logic signed [33:0] sum_t_q, sum_r_q, sum_p_q, sum_y_q;
  logic signed [31:0] arm_s, tc_s;
  logic signed [31:0] thrust_q;
  logic signed [65:0] roll_q, pitch_q, yaw_q;

  assign f0 = 34'($signed(f_i[0]));
  assign f1 = 34'($signed(f_i[1]));
  assign f2 = 34'($signed(f_i[2]));
  assign f3 = 34'($signed(f_i[3]));

  assign arm_s = $signed({1'b0, arm_offset_i});
  assign tc_s  = $signed({1'b0, torque_coeff_i});

  // signed sums of the four applied thrusts
  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      sum_t_q <= f0 + f1 + f2 + f3;
      sum_r_q <= f2 + f3 - f0 - f1;
      sum_p_q <= f0 + f3 - f1 - f2;
      sum_y_q <= f1 + f3 - f0 - f2;
    end
  end

  // scale by arm offset and torque coefficient
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      thrust_q <= sat32(66'(sum_t_q));
      roll_q   <= 66'(arm_s) * 66'(sum_r_q);
      pitch_q  <= 66'(arm_s) * 66'(sum_p_q);
      yaw_q    <= 66'(tc_s) * 66'(sum_y_q);
    end
  end

  assign thrust_o     = thrust_q;
  assign roll_prod_o  = roll_q;
  assign pitch_prod_o = pitch_q;
  assign yaw_prod_o   = yaw_q;

endmodule

`default_nettype wire

### rtl/quad_x_motor_mixer_unit.sv
`default_nettype none

// channel  | modport | transfer moves
// ---------+---------+-------------------------------------------------
// cfg_i    | sink    | register index and write data, always ready
// in_i     | sink    | thrust, three torques, torque flag, failed mask
// out_o    | source  | four motor thrusts and the achieved wrench
//
// Seven register stages: input, gain products, rounding, motor lanes, wrench
// sums, wrench products, output. The pipeline takes one command per cycle
// while out_o.ready accepts the results.
// Each stage holds only while full and blocked downstream, so bubbles fill
// while a result waits at the output. Reset clears the stage valids and loads
// the register reset values; datapath registers are not reset.

module quad_x_motor_mixer_unit import qxmm_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  qxmm_cfg_if.sink     cfg_i,
  qxmm_in_if.sink      in_i,
  qxmm_out_if.source   out_o
);

  localparam int unsigned TERM_W = 64 - FRACTION_BITS;
  localparam logic signed [63:0] HALF64 = 64'sd1 <<< (FRACTION_BITS - 1);
  localparam logic signed [65:0] HALF66 = 66'sd1 <<< (FRACTION_BITS - 1);

  // configuration registers
  logic [30:0]        arm_offset_q, torque_coeff_q, rp_gain_q, yaw_gain_q;
  logic signed [31:0] floor_q, ceiling_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_offset_q   <= ARM_OFFSET_RST;
      torque_coeff_q <= TORQUE_COEFF_RST;
      rp_gain_q      <= ROLL_PITCH_GN_RST;
      yaw_gain_q     <= YAW_GAIN_RST;
      floor_q        <= THRUST_FLOOR_RST;
      ceiling_q      <= THRUST_CEILING_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ARM_OFFSET:     arm_offset_q   <= cfg_i.data[30:0];
        REG_TORQUE_COEFF:   torque_coeff_q <= cfg_i.data[30:0];
        REG_ROLL_PITCH_GN:  rp_gain_q      <= cfg_i.data[30:0];
        REG_YAW_GAIN:       yaw_gain_q     <= cfg_i.data[30:0];
        REG_THRUST_FLOOR:   floor_q        <= $signed(cfg_i.data);
        REG_THRUST_CEILING: ceiling_q      <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  // stage valids and load enables
  logic [6:1] valid_q, valid_d;
  logic       out_valid_q, out_valid_d;
  logic [7:1] en;

  always_comb begin
    en[7] = !out_valid_q || out_o.ready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[1] = en[1] ? in_i.valid : valid_q[1];
    for (int k = 2; k <= 6; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
    out_valid_d = en[7] ? valid_q[6] : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_i.ready  = en[1];
  assign out_o.valid = out_valid_q;

  // input stage, torques gated by the present flag
  logic signed [31:0] t1_q, r1_q, p1_q, y1_q;
  logic [3:0]         mask1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      t1_q    <= in_i.thrust_command;
      r1_q    <= in_i.torque_present ? in_i.roll_torque  : 32'sd0;
      p1_q    <= in_i.torque_present ? in_i.pitch_torque : 32'sd0;
      y1_q    <= in_i.torque_present ? in_i.yaw_torque   : 32'sd0;
      mask1_q <= in_i.failed_mask;
    end
  end

  // gain products and the rounded quarter thrust
  logic signed [32:0] t_plus;
  logic signed [31:0] rp_gain_s, yaw_gain_s;
  logic signed [30:0] base2_q;
  logic signed [63:0] prod2_q [3];
  logic [3:0]         mask2_q;

  assign t_plus     = 33'(t1_q) + 33'sd2;
  assign rp_gain_s  = $signed({1'b0, rp_gain_q});
  assign yaw_gain_s = $signed({1'b0, yaw_gain_q});

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      base2_q             <= t_plus[32:2];
      prod2_q[AXIS_ROLL]  <= 64'(rp_gain_s) * 64'(r1_q);
      prod2_q[AXIS_PITCH] <= 64'(rp_gain_s) * 64'(p1_q);
      prod2_q[AXIS_YAW]   <= 64'(yaw_gain_s) * 64'(y1_q);
      mask2_q             <= mask1_q;
    end
  end

  // rounding of each product for both column signs, ties go up
  logic signed [63:0]          pos_sh [3];
  logic signed [63:0]          neg_sh [3];
  logic [2:0][1:0][TERM_W-1:0] terms_d, terms3_q;
  logic signed [30:0]          base3_q;
  logic [3:0]                  mask3_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos_sh[a] = (prod2_q[a] + HALF64) >>> FRACTION_BITS;
      neg_sh[a] = (HALF64 - prod2_q[a]) >>> FRACTION_BITS;
      terms_d[a][0] = pos_sh[a][TERM_W-1:0];
      terms_d[a][1] = neg_sh[a][TERM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      terms3_q <= terms_d;
      base3_q  <= base2_q;
      mask3_q  <= mask2_q;
    end
  end

  // motor lanes
  logic [3:0][31:0] f4;

  for (genvar i = 0; i < MOTORS; i++) begin : g_lane
    logic signed [31:0] f_lane;

    qxmm_lane #(
      .LANE_ID (i),
      .TERM_W  (TERM_W)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (en[4]),
      .base_i    (base3_q),
      .terms_i   (terms3_q),
      .failed_i  (mask3_q[i]),
      .floor_i   (floor_q),
      .ceiling_i (ceiling_q),
      .f_o       (f_lane)
    );

    assign f4[i] = f_lane;
  end

  // motor thrusts follow the merge stages
  logic [3:0][31:0] f5_q, f6_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      f5_q <= f4;
    end
    if (en[6]) begin
      f6_q <= f5_q;
    end
  end

  // wrench merge
  qxmm_merge_ctl_t    merge_ctl;
  logic signed [31:0] thrust6;
  logic signed [65:0] roll6, pitch6, yaw6;

  assign merge_ctl.sum_en = en[5];
  assign merge_ctl.mul_en = en[6];

  qxmm_merge u_merge (
    .clk_i          (clk_i),
    .ctl_i          (merge_ctl),
    .f_i            (f4),
    .arm_offset_i   (arm_offset_q),
    .torque_coeff_i (torque_coeff_q),
    .thrust_o       (thrust6),
    .roll_prod_o    (roll6),
    .pitch_prod_o   (pitch6),
    .yaw_prod_o     (yaw6)
  );

  // output register: round and saturate the wrench
  logic signed [65:0] roll_rnd, pitch_rnd, yaw_rnd;
  logic [3:0][31:0]   f_out_q;
  logic signed [31:0] thrust_out_q, roll_out_q, pitch_out_q, yaw_out_q;

  assign roll_rnd  = (roll6 + HALF66) >>> FRACTION_BITS;
  assign pitch_rnd = (pitch6 + HALF66) >>> FRACTION_BITS;
  assign yaw_rnd   = (yaw6 + HALF66) >>> FRACTION_BITS;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      f_out_q      <= f6_q;
      thrust_out_q <= thrust6;
      roll_out_q   <= sat32(roll_rnd);
      pitch_out_q  <= sat32(pitch_rnd);
      yaw_out_q    <= sat32(yaw_rnd);
    end
  end

  assign out_o.motor_one_thrust   = $signed(f_out_q[0]);
  assign out_o.motor_two_thrust   = $signed(f_out_q[1]);
  assign out_o.motor_three_thrust = $signed(f_out_q[2]);
  assign out_o.motor_four_thrust  = $signed(f_out_q[3]);
  assign out_o.achieved_thrust    = thrust_out_q;
  assign out_o.achieved_roll      = roll_out_q;
  assign out_o.achieved_pitch     = pitch_out_q;
  assign out_o.achieved_yaw       = yaw_out_q;

endmodule

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top;
  import qxmm_pkg::*;

  localparam int FRAC = 16;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int DRAIN_CYCLES = 16;

  // indexes that map to no register
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // kinds of register setting for the random phases
  typedef enum int {
    CFG_PLAUSIBLE,
    CFG_EXTREME,
    CFG_ANY
  } cfg_kind_e;

  typedef struct packed {
    logic signed [31:0] thrust;
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic               torque_present;
    logic [3:0]         failed_mask;
  } mix_cmd_t;

  typedef struct packed {
    logic signed [31:0] motor_one_thrust;
    logic signed [31:0] motor_two_thrust;
    logic signed [31:0] motor_three_thrust;
    logic signed [31:0] motor_four_thrust;
    logic signed [31:0] achieved_thrust;
    logic signed [31:0] achieved_roll;
    logic signed [31:0] achieved_pitch;
    logic signed [31:0] achieved_yaw;
  } mix_result_t;

  logic clk;
  logic rst_n;

  qxmm_cfg_if cfg_if ();
  qxmm_in_if  cmd_if ();
  qxmm_out_if res_if ();

  quad_x_motor_mixer_unit #(
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  // shadow copy of the register file
  longint arm_offset_r       = longint'(ARM_OFFSET_RST);
  longint torque_coeff_r     = longint'(TORQUE_COEFF_RST);
  longint roll_pitch_gain_r  = longint'(ROLL_PITCH_GN_RST);
  longint yaw_gain_r         = longint'(YAW_GAIN_RST);
  longint thrust_floor_r     = longint'(THRUST_FLOOR_RST);
  longint thrust_ceiling_r   = longint'(THRUST_CEILING_RST);

  mix_result_t expected_mix_q[$];
  int          error_count = 0;
  bit          send_gaps_en = 1'b1;
  bit          recv_stall_en = 1'b1;

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // q-format product rounding, half toward plus infinity
  function automatic logic signed [127:0] round_q(input logic signed [127:0] v);
    return (v + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -128'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // motor allocation, clamp, failure and achieved wrench
  function automatic mix_result_t predict_mix(input mix_cmd_t c);
    logic signed [127:0] r, p, y, v, base, lo, hi, rp_k, yw_k, arm_k, tc_k;
    logic signed [127:0] f [4];
    mix_result_t e;
    int i;
    r = '0;
    p = '0;
    y = '0;
    rp_k = 128'(roll_pitch_gain_r);
    yw_k = 128'(yaw_gain_r);
    arm_k = 128'(arm_offset_r);
    tc_k = 128'(torque_coeff_r);
    lo = 128'(thrust_floor_r);
    hi = 128'(thrust_ceiling_r);
    if (c.torque_present) begin
      r = 128'(c.roll);
      p = 128'(c.pitch);
      y = 128'(c.yaw);
    end
    base = (128'(c.thrust) + 128'sd2) >>> 2;
    for (i = 0; i < MOTORS; i++) begin
      v = base + round_q(rp_k * (ROLL_NEG[i] ? -r : r))
               + round_q(rp_k * (PITCH_NEG[i] ? -p : p))
               + round_q(yw_k * (YAW_NEG[i] ? -y : y));
      if (v > hi) v = hi;
      // floor wins when it sits above the ceiling
      if (v < lo) v = lo;
      if (c.failed_mask[i]) v = '0;
      f[i] = v;
    end
    e.motor_one_thrust   = f[0][31:0];
    e.motor_two_thrust   = f[1][31:0];
    e.motor_three_thrust = f[2][31:0];
    e.motor_four_thrust  = f[3][31:0];
    e.achieved_thrust    = clip32(f[0] + f[1] + f[2] + f[3]);
    e.achieved_roll      = clip32(round_q(arm_k * (-f[0] - f[1] + f[2] + f[3])));
    e.achieved_pitch     = clip32(round_q(arm_k * (f[0] - f[1] - f[2] + f[3])));
    e.achieved_yaw       = clip32(round_q(tc_k * (-f[0] + f[1] - f[2] + f[3])));
    return e;
  endfunction

  // append one expectation at the tail of the queue
  task automatic enqueue_expected(input mix_result_t e);
    expected_mix_q = {expected_mix_q, e};
  endtask

  // one command transfer, with a random gap ahead of it
  task automatic send_command(input mix_cmd_t c);
    int gap;
    gap = send_gaps_en ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.thrust_command <= c.thrust;
    cmd_if.roll_torque    <= c.roll;
    cmd_if.pitch_torque   <= c.pitch;
    cmd_if.yaw_torque     <= c.yaw;
    cmd_if.torque_present <= c.torque_present;
    cmd_if.failed_mask    <= c.failed_mask;
    cmd_if.valid          <= 1'b1;
    do @(posedge clk); while (!cmd_if.ready);
    enqueue_expected(predict_mix(c));
  endtask

  task automatic send_fields(input logic signed [31:0] t, r, p, y,
                             input logic tp, input logic [3:0] mask);
    mix_cmd_t c;
    c.thrust = t;
    c.roll = r;
    c.pitch = p;
    c.yaw = y;
    c.torque_present = tp;
    c.failed_mask = mask;
    send_command(c);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (expected_mix_q.size() != 0) @(posedge clk);
  endtask

  // register write transfer, shadow updated on acceptance
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_ARM_OFFSET:     arm_offset_r      = longint'(data[30:0]);
      REG_TORQUE_COEFF:   torque_coeff_r    = longint'(data[30:0]);
      REG_ROLL_PITCH_GN:  roll_pitch_gain_r = longint'(data[30:0]);
      REG_YAW_GAIN:       yaw_gain_r        = longint'(data[30:0]);
      REG_THRUST_FLOOR:   thrust_floor_r    = longint'($signed(data));
      REG_THRUST_CEILING: thrust_ceiling_r  = longint'($signed(data));
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [31:0] arm, tc, grp, gy, lo, hi);
    write_reg(REG_ARM_OFFSET, arm);
    write_reg(REG_TORQUE_COEFF, tc);
    write_reg(REG_ROLL_PITCH_GN, grp);
    write_reg(REG_YAW_GAIN, gy);
    write_reg(REG_THRUST_FLOOR, lo);
    write_reg(REG_THRUST_CEILING, hi);
  endtask

  // one of the boundary values, or anything
  function automatic logic [31:0] pick_edge();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic mix_cmd_t rand_command();
    mix_cmd_t c;
    case ($urandom_range(0, 3))
      0: begin
        c.thrust = $urandom;
        c.roll = $urandom;
        c.pitch = $urandom;
        c.yaw = $urandom;
      end
      3: begin
        c.thrust = pick_edge();
        c.roll = pick_edge();
        c.pitch = pick_edge();
        c.yaw = pick_edge();
      end
      default: begin
        // flight-like magnitudes
        c.thrust = $urandom_range(0, 40 << 16) - (2 << 16);
        c.roll = $urandom_range(0, 1 << 18) - (1 << 17);
        c.pitch = $urandom_range(0, 1 << 18) - (1 << 17);
        c.yaw = $urandom_range(0, 1 << 16) - (1 << 15);
      end
    endcase
    c.torque_present = ($urandom_range(0, 7) != 0);
    c.failed_mask = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
    return c;
  endfunction

  task automatic randomize_config(input cfg_kind_e kind);
    logic [31:0] lo;
    case (kind)
      CFG_PLAUSIBLE: begin
        lo = $urandom_range(0, 1 << 16);
        write_all_regs($urandom_range(1 << 14, 1 << 19), $urandom_range(1 << 10, 1 << 17),
                       $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                       lo, lo + $urandom_range(1 << 16, 40 << 16));
      end
      CFG_EXTREME: begin
        write_all_regs(32'h7FFF_FFFF, $urandom | 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      end
      default: begin
        write_all_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    endcase
  endtask

  // boundary commands under the reset register values
  task automatic test_reset_defaults();
    send_fields(0, 0, 0, 0, 1'b0, 4'h0);
    send_fields(4 << 16, 1 << 14, -(1 << 14), 1 << 12, 1'b1, 4'h0);
    send_fields(32'sh7FFF_FFFF, 0, 0, 0, 1'b1, 4'h0);
    send_fields(32'sh8000_0000, 0, 0, 0, 1'b1, 4'h0);
    send_fields(8 << 16, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 4'h0);
    send_fields(8 << 16, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 4'h0);
    // torques ignored when flagged absent
    send_fields(8 << 16, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 4'h0);
    send_fields(6 << 16, 1 << 15, 1 << 15, 1 << 15, 1'b1, 4'h1);
    send_fields(6 << 16, 1 << 15, 1 << 15, 1 << 15, 1'b1, 4'h2);
    send_fields(6 << 16, 1 << 15, 1 << 15, 1 << 15, 1'b1, 4'h4);
    send_fields(6 << 16, 1 << 15, 1 << 15, 1 << 15, 1'b1, 4'h8);
    // all motors out
    send_fields(20 << 16, 1 << 16, -(1 << 16), 1 << 16, 1'b1, 4'hF);
    send_fields(-1, -1, -1, -1, 1'b1, 4'h0);
  endtask

  task automatic test_floor_above_ceiling();
    drain_results();
    write_reg(REG_THRUST_FLOOR, 5 << 16);
    write_reg(REG_THRUST_CEILING, 2 << 16);
    send_fields(0, 0, 0, 0, 1'b1, 4'h0);
    send_fields(32 << 16, 1 << 18, -(1 << 18), 1 << 18, 1'b1, 4'h6);
  endtask

  // gains used as written, wrench saturation
  task automatic test_huge_wrench();
    drain_results();
    write_all_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF);
    send_fields(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 4'h0);
    send_fields(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 4'h0);
    send_fields(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 4'h9);
    drain_results();
    write_all_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF);
    send_fields(12 << 16, 1 << 20, 1 << 20, 32'sh8000_0000, 1'b1, 4'h0);
  endtask

  // writes to unmapped indexes change nothing
  task automatic test_unknown_index();
    drain_results();
    write_all_regs(32'(ARM_OFFSET_RST), 32'(TORQUE_COEFF_RST), 32'(ROLL_PITCH_GN_RST),
                   32'(YAW_GAIN_RST), THRUST_FLOOR_RST, THRUST_CEILING_RST);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h8000_0001);
    send_fields(9 << 16, 1 << 16, 1 << 15, -(1 << 15), 1'b1, 4'h0);
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    cfg_kind_e kind;
    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      kind = (phase == 1) ? CFG_EXTREME : ((phase % 3 == 2) ? CFG_ANY : CFG_PLAUSIBLE);
      randomize_config(kind);
      // one phase runs back to back with no idling
      send_gaps_en = (phase != 3);
      recv_stall_en = (phase != 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == PHASE_ITEMS / 2) drain_results();
        send_command(rand_command());
      end
    end
    send_gaps_en = 1'b1;
    recv_stall_en = 1'b1;
  endtask

  // result sink with random stalls
  initial begin : result_sink
    int stall;
    res_if.ready = 1'b0;
    forever begin
      stall = recv_stall_en ? $urandom_range(0, 4) : 0;
      repeat (stall) begin
        @(negedge clk);
        res_if.ready <= 1'b0;
      end
      @(negedge clk);
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // compare every result transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    mix_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_mix_q.size() == 0) begin
        $error("result transfer with no expected result");
        error_count++;
      end else begin
        want = expected_mix_q.pop_front();
        compare_field("motor_one_thrust", want.motor_one_thrust, res_if.motor_one_thrust);
        compare_field("motor_two_thrust", want.motor_two_thrust, res_if.motor_two_thrust);
        compare_field("motor_three_thrust", want.motor_three_thrust,
                      res_if.motor_three_thrust);
        compare_field("motor_four_thrust", want.motor_four_thrust, res_if.motor_four_thrust);
        compare_field("achieved_thrust", want.achieved_thrust, res_if.achieved_thrust);
        compare_field("achieved_roll", want.achieved_roll, res_if.achieved_roll);
        compare_field("achieved_pitch", want.achieved_pitch, res_if.achieved_pitch);
        compare_field("achieved_yaw", want.achieved_yaw, res_if.achieved_yaw);
      end
    end
  end

  // run limit
  initial begin : run_limit
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin : main_sequence
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    cmd_if.valid = 1'b0;
    cmd_if.thrust_command = '0;
    cmd_if.roll_torque = '0;
    cmd_if.pitch_torque = '0;
    cmd_if.yaw_torque = '0;
    cmd_if.torque_present = 1'b0;
    cmd_if.failed_mask = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_floor_above_ceiling();
    test_huge_wrench();
    test_unknown_index();
    test_random_traffic();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_mix_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
